// ===== src/complement_byte_message_framer_assert.svh =====
`ifndef COMPLEMENT_BYTE_MESSAGE_FRAMER_ASSERT_SVH
`define COMPLEMENT_BYTE_MESSAGE_FRAMER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define CBMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define CBMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/cbmf_pkg.sv =====
`default_nettype none

package cbmf_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0] HDR_SYNC      = 8'h55;
    localparam logic [7:0] HDR_MARK      = 8'hFF;
    localparam logic [7:0] HDR_ZERO      = 8'h00;
    localparam logic [7:0] TOGGLE_WEIGHT = 8'h08;

    // one classified message byte
    typedef struct packed {
        logic       hdr;
        logic       last;
        logic [7:0] data;
        logic [7:0] sum;
    } entry_t;

    typedef enum logic [6:0] {
        ST_SYNC = 7'b0000001,
        ST_MARK = 7'b0000010,
        ST_ZERO = 7'b0000100,
        ST_BYTE = 7'b0001000,
        ST_CPL  = 7'b0010000,
        ST_SUM  = 7'b0100000,
        ST_SUMC = 7'b1000000
    } step_t;

endpackage

`default_nettype wire

// ===== src/cbmf_front.sv =====
`default_nettype none

module cbmf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        msg_byte,
    input  wire logic              is_opcode,
    input  wire logic              is_last,
    input  wire logic              q_full,
    output logic                   q_push,
    output cbmf_pkg::entry_t       q_entry
);

    logic       toggle_reg;
    logic       toggle_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] data_c;
    logic [7:0] sum_c;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        data_c = msg_byte;
        if (is_opcode && toggle_reg)
        begin
            data_c = msg_byte | cbmf_pkg::TOGGLE_WEIGHT;
        end
        sum_c = is_opcode ? data_c : sum_reg + msg_byte;

        q_entry.hdr  = is_opcode;
        q_entry.last = is_last;
        q_entry.data = data_c;
        q_entry.sum  = sum_c;

        toggle_next = toggle_reg;
        sum_next    = sum_reg;
        if (q_push)
        begin
            toggle_next = toggle_reg ^ is_opcode;
            sum_next    = is_last ? 8'h00 : sum_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= 1'b0;
            sum_reg    <= 8'h00;
        end
        else
        begin
            toggle_reg <= toggle_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/cbmf_queue.sv =====
`default_nettype none

module cbmf_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  cbmf_pkg::entry_t       push_entry,
    input  wire logic              pop,
    output logic                   full,
    output logic                   head_valid,
    output cbmf_pkg::entry_t       head
);

    cbmf_pkg::entry_t                 mem_reg [cbmf_pkg::QDEPTH];
    logic [cbmf_pkg::QAW-1:0]         wr_ptr_reg;
    logic [cbmf_pkg::QAW-1:0]         wr_ptr_next;
    logic [cbmf_pkg::QAW-1:0]         rd_ptr_reg;
    logic [cbmf_pkg::QAW-1:0]         rd_ptr_next;
    logic [cbmf_pkg::QCW-1:0]         count_reg;
    logic [cbmf_pkg::QCW-1:0]         count_next;

    assign full       = (count_reg == cbmf_pkg::QCW'(cbmf_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == cbmf_pkg::QAW'(cbmf_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cbmf_pkg::QAW'(cbmf_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/cbmf_back.sv =====
`default_nettype none

module cbmf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  cbmf_pkg::entry_t       head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             frame_byte,
    output logic                   frame_end
);

    logic                 busy_reg;
    logic                 busy_next;
    cbmf_pkg::step_t      step_reg;
    cbmf_pkg::step_t      step_next;
    cbmf_pkg::entry_t     cur_reg;
    cbmf_pkg::entry_t     cur_next;
    logic                 ovalid_reg;
    logic                 ovalid_next;
    logic [7:0]           obyte_reg;
    logic [7:0]           obyte_next;
    logic                 oend_reg;
    logic                 oend_next;

    cbmf_pkg::entry_t     act;
    cbmf_pkg::step_t      act_step;
    cbmf_pkg::step_t      adv_step;
    logic                 act_valid;
    logic                 take;
    logic                 final_c;
    logic [7:0]           byte_c;
    logic                 end_c;

    assign out_valid  = ovalid_reg;
    assign frame_byte = obyte_reg;
    assign frame_end  = oend_reg;

    always_comb
    begin
        act       = busy_reg ? cur_reg : head;
        act_valid = busy_reg || head_valid;
        if (busy_reg)
        begin
            act_step = step_reg;
        end
        else
        begin
            act_step = head.hdr ? cbmf_pkg::ST_SYNC : cbmf_pkg::ST_BYTE;
        end
        take = act_valid && (!ovalid_reg || out_ready);
        pop  = take && !busy_reg;

        byte_c   = act.data;
        end_c    = 1'b0;
        final_c  = 1'b0;
        adv_step = cbmf_pkg::ST_BYTE;
        case (act_step)
            cbmf_pkg::ST_SYNC:
            begin
                byte_c   = cbmf_pkg::HDR_SYNC;
                adv_step = cbmf_pkg::ST_MARK;
            end
            cbmf_pkg::ST_MARK:
            begin
                byte_c   = cbmf_pkg::HDR_MARK;
                adv_step = cbmf_pkg::ST_ZERO;
            end
            cbmf_pkg::ST_ZERO:
            begin
                byte_c   = cbmf_pkg::HDR_ZERO;
                adv_step = cbmf_pkg::ST_BYTE;
            end
            cbmf_pkg::ST_BYTE:
            begin
                byte_c   = act.data;
                adv_step = cbmf_pkg::ST_CPL;
            end
            cbmf_pkg::ST_CPL:
            begin
                byte_c   = ~act.data;
                final_c  = !act.last;
                adv_step = cbmf_pkg::ST_SUM;
            end
            cbmf_pkg::ST_SUM:
            begin
                byte_c   = act.sum;
                adv_step = cbmf_pkg::ST_SUMC;
            end
            cbmf_pkg::ST_SUMC:
            begin
                byte_c  = ~act.sum;
                end_c   = 1'b1;
                final_c = 1'b1;
            end
            default:
            begin
                byte_c  = act.data;
                final_c = 1'b1;
            end
        endcase

        busy_next   = busy_reg;
        step_next   = step_reg;
        cur_next    = cur_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        oend_next   = oend_reg;
        if (take)
        begin
            busy_next   = !final_c;
            step_next   = adv_step;
            cur_next    = act;
            ovalid_next = 1'b1;
            obyte_next  = byte_c;
            oend_next   = end_c;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        oend_reg  <= oend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= cbmf_pkg::ST_SYNC;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/complement_byte_message_framer.sv =====
// Path: an accepted transfer goes to the queue, then to the registered output byte.
// Throughput: one output byte per cycle, set by the sequencer, while m_axis_tready holds;
//   body byte: byte, ~byte; opcode: 55 FF 00 first; last byte: sum, ~sum after.
// A 4-entry queue lets input keep flowing while the output side stalls.
// Reset (rst_n low, async): toggle bit and running sum cleared, queue and output emptied.
`default_nettype none

module complement_byte_message_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] is_opcode
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] frame_byte
    output logic             m_axis_tlast    // frame_end
);

    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    cbmf_pkg::entry_t    q_in;
    cbmf_pkg::entry_t    q_head;

    cbmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .msg_byte  (s_axis_tdata),
        .is_opcode (s_axis_tuser[0]),
        .is_last   (s_axis_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    cbmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    cbmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .frame_byte (m_axis_tdata),
        .frame_end  (m_axis_tlast)
    );

`include "complement_byte_message_framer_assert.svh"

    `CBMF_ASSERT_NOW(a_pop_has_head, q_pop, q_valid)
    `CBMF_ASSERT_NOW(a_push_has_room, q_push, !q_full)
    `CBMF_ASSERT_NEXT(a_pop_frees_slot, q_pop && !q_push, !q_full)

endmodule

`default_nettype wire
